// File: src/gpe_pkg.sv
package gpe_pkg;

    localparam int GLYPH_SIZE  = 8;
    localparam int GLYPH_BITS  = GLYPH_SIZE * GLYPH_SIZE;
    localparam int PIX_IDX_W   = $clog2(GLYPH_BITS);
    localparam int ROW_IDX_W   = $clog2(GLYPH_SIZE);

    localparam int COORD_W     = 13;
    localparam int CODE_W      = 7;
    localparam int COLOR_W     = 8;
    localparam int PIXEL_W     = 3 * COLOR_W;
    localparam int PITCH_W     = 16;
    localparam int STRIDE_W    = PITCH_W - 2;
    localparam int OFFSET_W    = 25;
    localparam int PROD_W      = COORD_W + STRIDE_W;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 56;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PITCH_BYTES   = 2'd2;

    localparam logic [COORD_W-1:0] RESET_WIDTH  = 13'd1024;
    localparam logic [COORD_W-1:0] RESET_HEIGHT = 13'd768;
    localparam logic [PITCH_W-1:0] RESET_PITCH  = 16'd4096;

    localparam logic [CODE_W-1:0] CHAR_BANG = 7'd33;
    localparam logic [CODE_W-1:0] CHAR_E    = 7'd69;
    localparam logic [CODE_W-1:0] CHAR_H    = 7'd72;
    localparam logic [CODE_W-1:0] CHAR_L    = 7'd76;
    localparam logic [CODE_W-1:0] CHAR_O    = 7'd79;

    // Whole glyph as one word: the top row sits in the top byte, and within
    // a row the leftmost pixel is the most significant bit.
    function automatic logic [GLYPH_BITS-1:0] glyph_bits(input logic [CODE_W-1:0] code);
        logic [GLYPH_BITS-1:0] g;
        case (code)
            CHAR_BANG: g = 64'h1818_1818_1800_1800;
            CHAR_E:    g = 64'hFF80_80FE_8080_FF00;
            CHAR_H:    g = 64'h8181_81FF_FF81_8181;
            CHAR_L:    g = 64'h8080_8080_8080_FF00;
            CHAR_O:    g = 64'hFF81_8181_8181_FF00;
            default:   g = '0;
        endcase
        return g;
    endfunction

endpackage

// File: src/glyph_pixel_expander.sv
// glyph_pixel_expander turns one character item (position, code, color) into
// the framebuffer writes of its 8x8 glyph, in row order from the top and,
// within a row, from the leftmost pixel. Pixels that are blank in the glyph
// or fall outside the configured screen produce nothing, and the final write
// of a character carries tlast; a character with no visible pixel produces no
// item at all. The pixel emitter delivers one write per cycle, unless the
// receiver holds off tready, through a single output register. The next
// character is accepted in the same cycle that the previous one's last
// write is loaded into the output register. Configuration writes are always
// accepted and belong between characters: the screen size is applied when a
// character is accepted, and the pitch while its writes are being emitted.
module glyph_pixel_expander (
    input  logic                            clk,
    input  logic                            rst_n,
    // Bits from the lowest up: origin_x[12:0], origin_y[25:13],
    // char_code[32:26], red[40:33], green[48:41], blue[56:49], zero fill.
    input  logic [gpe_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // Bits from the lowest up: word_offset[24:0], pixel_word[48:25], zero fill.
    output logic [gpe_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // last_write: high on the final write of a character.
    output logic                            m_axis_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gpe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gpe_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import gpe_pkg::*;

    // Configuration registers.
    logic [COORD_W-1:0] width_reg;
    logic [COORD_W-1:0] height_reg;
    logic [PITCH_W-1:0] pitch_reg;

    // Current character: remaining visible pixels, origin and color.
    logic [GLYPH_BITS-1:0] pend_reg, pend_next;
    logic [COORD_W-1:0]    ox_reg;
    logic [COORD_W-1:0]    oy_reg;
    logic [PIXEL_W-1:0]    color_reg;

    // Output register.
    logic                  out_valid_reg;
    logic [OFFSET_W-1:0]   out_offset_reg;
    logic [PIXEL_W-1:0]    out_pixel_reg;
    logic                  out_last_reg;

    // Input fields.
    logic [COORD_W-1:0] in_ox;
    logic [COORD_W-1:0] in_oy;
    logic [CODE_W-1:0]  in_code;
    logic [PIXEL_W-1:0] in_color;

    assign in_ox    = s_axis_tdata[12:0];
    assign in_oy    = s_axis_tdata[25:13];
    assign in_code  = s_axis_tdata[32:26];
    assign in_color = {s_axis_tdata[40:33], s_axis_tdata[48:41], s_axis_tdata[56:49]};

    // Visibility mask of an incoming character. Bit r*8+c is row r, column c,
    // so the lowest set bit is always the next write in scan order.
    logic [GLYPH_BITS-1:0] glyph;
    logic [GLYPH_SIZE-1:0] col_ok;
    logic [GLYPH_SIZE-1:0] row_ok;
    logic [GLYPH_BITS-1:0] in_mask;
    logic [COORD_W:0]      xc [GLYPH_SIZE];
    logic [COORD_W:0]      yc [GLYPH_SIZE];

    always_comb
    begin
        glyph = glyph_bits(in_code);
        for (int i = 0; i < GLYPH_SIZE; i++)
        begin
            xc[i]     = {in_ox[COORD_W-1], in_ox} + (COORD_W+1)'(i);
            yc[i]     = {in_oy[COORD_W-1], in_oy} + (COORD_W+1)'(i);
            col_ok[i] = !xc[i][COORD_W] && (xc[i][COORD_W-1:0] < width_reg);
            row_ok[i] = !yc[i][COORD_W] && (yc[i][COORD_W-1:0] < height_reg);
        end
        for (int r = 0; r < GLYPH_SIZE; r++)
        begin
            for (int c = 0; c < GLYPH_SIZE; c++)
            begin
                in_mask[r*GLYPH_SIZE + c] = glyph[GLYPH_BITS-1 - (r*GLYPH_SIZE + c)]
                                            & col_ok[c] & row_ok[r];
            end
        end
    end

    // Pick the next pending pixel: isolate the lowest set bit and encode it.
    logic [GLYPH_BITS-1:0] pick;
    logic [GLYPH_BITS-1:0] pend_rest;
    logic [PIX_IDX_W-1:0]  pick_idx;
    logic                  pick_last;
    logic                  out_adv;
    logic                  emit;

    always_comb
    begin
        pick     = pend_reg & (~pend_reg + GLYPH_BITS'(1));
        pick_idx = '0;
        for (int i = 0; i < GLYPH_BITS; i++)
        begin
            if (pick[i])
            begin
                pick_idx = pick_idx | PIX_IDX_W'(i);
            end
        end
    end

    assign pend_rest = pend_reg & ~pick;
    assign pick_last = (pend_rest == '0);
    assign out_adv   = !out_valid_reg || m_axis_tready;
    assign emit      = (pend_reg != '0) && out_adv;

    // A new character may enter once nothing of the current one stays pending.
    assign s_axis_tready = (pend_reg == '0) || (emit && pick_last);
    assign cfg_ready     = 1'b1;

    // Address of the picked pixel.
    logic [ROW_IDX_W-1:0] pick_row;
    logic [ROW_IDX_W-1:0] pick_col;
    logic [COORD_W-1:0]   px;
    logic [COORD_W-1:0]   py;
    logic [STRIDE_W-1:0]  stride;
    logic [PROD_W-1:0]    prod;
    logic [OFFSET_W-1:0]  offset;

    assign pick_row = pick_idx[PIX_IDX_W-1:ROW_IDX_W];
    assign pick_col = pick_idx[ROW_IDX_W-1:0];
    assign px       = ox_reg + COORD_W'(pick_col);
    assign py       = oy_reg + COORD_W'(pick_row);
    assign stride   = pitch_reg[PITCH_W-1:2];
    assign prod     = PROD_W'(py) * PROD_W'(stride);
    assign offset   = OFFSET_W'(prod + PROD_W'(px));

    always_comb
    begin
        pend_next = emit ? pend_rest : pend_reg;
        if (s_axis_tvalid && s_axis_tready)
        begin
            pend_next = in_mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= RESET_WIDTH;
            height_reg    <= RESET_HEIGHT;
            pitch_reg     <= RESET_PITCH;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_SCREEN_WIDTH:  width_reg  <= cfg_data[COORD_W-1:0];
                    REG_SCREEN_HEIGHT: height_reg <= cfg_data[COORD_W-1:0];
                    REG_PITCH_BYTES:   pitch_reg  <= cfg_data;
                    default:           ;
                endcase
            end
            pend_reg <= pend_next;
            if (out_adv)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            ox_reg    <= in_ox;
            oy_reg    <= in_oy;
            color_reg <= in_color;
        end
        if (emit)
        begin
            out_offset_reg <= offset;
            out_pixel_reg  <= color_reg;
            out_last_reg   <= pick_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - OFFSET_W - PIXEL_W)'(0), out_pixel_reg,
                            out_offset_reg};

    // A pixel loaded into an empty or draining output register shows up next.
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> m_axis_tvalid)
        else $error("pixel write lost on its way to the output register");

    // A new character never overwrites pixels that are still pending.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |-> ((pend_reg == '0) || (emit && pend_rest == '0)))
        else $error("character accepted while pixels remain");

    // The picker selects at most one pixel.
    a_pick_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(pick))
        else $error("pixel picker selected several bits");

    // A write that is not the last leaves more work behind.
    a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !pick_last) |=> (pend_reg != '0))
        else $error("pending pixels vanished before the last write");

endmodule

// File: verif/glyph_write_checker.sv
module glyph_write_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [gpe_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [gpe_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic                            m_axis_tlast,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [gpe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gpe_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              mismatches,
    output int                              pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import gpe_pkg::*;

    localparam int FILL_W = IN_TDATA_W - 2 * COORD_W - CODE_W - 3 * COLOR_W;
    localparam int REPORT_CAP = 200;

    typedef struct packed {
        logic [FILL_W-1:0]  fill;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
        logic [CODE_W-1:0]  char_code;
        logic [COORD_W-1:0] origin_y;
        logic [COORD_W-1:0] origin_x;
    } char_item_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] word_offset;
        logic [PIXEL_W-1:0]  pixel_word;
        logic                last_write;
    } pixel_write_t;

    pixel_write_t       writes_due[$];
    logic [COORD_W-1:0] width_q;
    logic [COORD_W-1:0] height_q;
    logic [PITCH_W-1:0] pitch_q;
    int                 fault_count;

    function automatic logic [GLYPH_SIZE-1:0] glyph_row(input logic [CODE_W-1:0] code,
                                                        input int row);
        logic [GLYPH_SIZE-1:0] rows [GLYPH_SIZE];
        case (code)
            CHAR_BANG: rows = '{8'h18, 8'h18, 8'h18, 8'h18, 8'h18, 8'h00, 8'h18, 8'h00};
            CHAR_E:    rows = '{8'hFF, 8'h80, 8'h80, 8'hFE, 8'h80, 8'h80, 8'hFF, 8'h00};
            CHAR_H:    rows = '{8'h81, 8'h81, 8'h81, 8'hFF, 8'hFF, 8'h81, 8'h81, 8'h81};
            CHAR_L:    rows = '{8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'hFF, 8'h00};
            CHAR_O:    rows = '{8'hFF, 8'h81, 8'h81, 8'h81, 8'h81, 8'h81, 8'hFF, 8'h00};
            default:   rows = '{default: 8'h00};
        endcase
        return rows[row];
    endfunction

    // Queues the visible pixel writes of one character; the final one is
    // held back so that it can be flagged as the last write.
    task automatic expand_glyph(input char_item_t item);
        int                    ox;
        int                    oy;
        int                    x;
        int                    y;
        longint                stride;
        longint                offset;
        logic [GLYPH_SIZE-1:0] bits;
        pixel_write_t          held;
        bit                    have_held;
        ox = int'($signed(item.origin_x));
        oy = int'($signed(item.origin_y));
        stride = longint'(pitch_q >> 2);
        have_held = 1'b0;
        held = '0;
        for (int r = 0; r < GLYPH_SIZE; r++) begin
            bits = glyph_row(item.char_code, r);
            y = oy + r;
            for (int c = 0; c < GLYPH_SIZE; c++) begin
                x = ox + c;
                if (bits[GLYPH_SIZE-1-c] && x >= 0 && x < int'(width_q)
                    && y >= 0 && y < int'(height_q)) begin
                    if (have_held)
                        writes_due.push_back(held);
                    offset = longint'(y) * stride + longint'(x);
                    held.word_offset = offset[OFFSET_W-1:0];
                    held.pixel_word = {item.red, item.green, item.blue};
                    held.last_write = 1'b0;
                    have_held = 1'b1;
                end
            end
        end
        if (have_held) begin
            held.last_write = 1'b1;
            writes_due.push_back(held);
        end
    endtask

    task automatic check_write();
        pixel_write_t        want;
        logic [OFFSET_W-1:0] got_offset;
        logic [PIXEL_W-1:0]  got_pixel;
        got_offset = m_axis_tdata[OFFSET_W-1:0];
        got_pixel = m_axis_tdata[OFFSET_W+PIXEL_W-1:OFFSET_W];
        if (writes_due.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_CAP)
                $display("%0t unexpected write: expected none, actual offset %0d pixel %h last %0b",
                         $time, got_offset, got_pixel, m_axis_tlast);
            return;
        end
        want = writes_due.pop_front();
        if (got_offset !== want.word_offset) begin
            fault_count++;
            if (fault_count <= REPORT_CAP)
                $display("%0t word_offset mismatch: expected %0d, actual %0d",
                         $time, want.word_offset, got_offset);
        end
        if (got_pixel !== want.pixel_word) begin
            fault_count++;
            if (fault_count <= REPORT_CAP)
                $display("%0t pixel_word mismatch: expected %h, actual %h",
                         $time, want.pixel_word, got_pixel);
        end
        if (m_axis_tlast !== want.last_write) begin
            fault_count++;
            if (fault_count <= REPORT_CAP)
                $display("%0t last_write mismatch: expected %0b, actual %0b",
                         $time, want.last_write, m_axis_tlast);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            width_q     <= RESET_WIDTH;
            height_q    <= RESET_HEIGHT;
            pitch_q     <= RESET_PITCH;
            fault_count = 0;
            mismatches  <= 0;
            pending     <= 0;
            writes_due.delete();
        end
        else begin
            if (m_axis_tvalid && m_axis_tready)
                check_write();
            if (s_axis_tvalid && s_axis_tready)
                expand_glyph(char_item_t'(s_axis_tdata));
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SCREEN_WIDTH:  width_q  <= cfg_data[COORD_W-1:0];
                    REG_SCREEN_HEIGHT: height_q <= cfg_data[COORD_W-1:0];
                    REG_PITCH_BYTES:   pitch_q  <= cfg_data;
                    default: ;
                endcase
            end
            mismatches <= fault_count;
            pending    <= writes_due.size();
        end
    end

endmodule

// File: verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gpe_pkg::*;

    localparam int FILL_W = IN_TDATA_W - 2 * COORD_W - CODE_W - 3 * COLOR_W;

    // Index 3 is not mapped to any register; writes to it must be dropped.
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 2'd3;

    // Codes at both ends of the range; neither has a glyph.
    localparam logic [CODE_W-1:0] CODE_LOWEST  = 7'd0;
    localparam logic [CODE_W-1:0] CODE_HIGHEST = 7'd127;

    // Margin after the predicted writes have drained, before a register
    // write or the verdict.
    localparam int DRAIN_CYCLES   = 100;
    localparam int LONG_HOLD      = 400;
    localparam int HOLD_AFTER     = 120;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PHASES  = 9;

    logic                   clk;
    logic                   rst_n         = 1'b0;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic                   m_axis_tlast;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;

    int mismatches;
    int pending;
    int items_sent    = 0;
    int quiet_cycles  = 0;
    bit sender_steady = 1'b0;

    // Visible area last programmed; only used to aim the random positions.
    int cur_width  = int'(RESET_WIDTH);
    int cur_height = int'(RESET_HEIGHT);

    logic [CODE_W-1:0] glyph_codes [5] = '{CHAR_BANG, CHAR_E, CHAR_H, CHAR_L, CHAR_O};

    glyph_pixel_expander uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // The checker watches all three channels on its own, so the stimulus
    // below never has to tell it what was sent.
    glyph_write_checker write_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Idle stretch lengths: mostly none or short, now and then a long one.
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        if (pick < 98)
            return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    // Picks a glyph origin along one axis. Most land fully on screen, the
    // rest straddle an edge, sit at the extremes of the field, or anywhere.
    function automatic int pick_coord(input int span);
        int hi;
        int sel;
        hi = (span > 4095) ? 4095 : span;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return int'($urandom_range(0, (hi > 8) ? hi - 8 : 0));
        if (sel == 6)
            return 0 - int'($urandom_range(0, 7));
        if (sel == 7)
            return hi - 8 + int'($urandom_range(0, 9));
        if (sel == 8)
            return int'($urandom_range(0, 8191)) - 4096;
        case ($urandom_range(0, 3))
            0:       return -4096;
            1:       return 4095;
            2:       return -8;
            default: return -1;
        endcase
    endfunction

    // Offers one character item and returns at the edge where it was taken.
    // The valid is only dropped when a gap is wanted, so back-to-back items
    // never see it lowered and raised in the same step.
    task automatic send_char(input int ox, input int oy, input logic [CODE_W-1:0] code,
                             input logic [COLOR_W-1:0] red, input logic [COLOR_W-1:0] green,
                             input logic [COLOR_W-1:0] blue);
        int gap;
        gap = sender_steady ? 0 : idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata  <= {{FILL_W{1'b0}}, blue, green, red, code,
                          oy[COORD_W-1:0], ox[COORD_W-1:0]};
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        items_sent <= items_sent + 1;
    endtask

    // Waits until every predicted write has arrived, then lets the block
    // finish any character that has no visible pixels.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Programs the screen geometry; optionally also pokes the unmapped index
    // with a value that would blank the screen if it were ever applied.
    task automatic set_screen(input logic [CFG_DATA_W-1:0] width,
                              input logic [CFG_DATA_W-1:0] height,
                              input logic [CFG_DATA_W-1:0] pitch, input bit poke_unmapped);
        logic [CFG_INDEX_W-1:0] idx [4];
        logic [CFG_DATA_W-1:0]  val [4];
        int                     count;
        idx = '{REG_SCREEN_WIDTH, REG_SCREEN_HEIGHT, REG_PITCH_BYTES, REG_UNMAPPED};
        val = '{width, height, pitch, 16'h0000};
        count = poke_unmapped ? 4 : 3;
        for (int i = 0; i < count; i++) begin
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            cfg_valid <= 1'b1;
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        cur_width  = int'(width[COORD_W-1:0]);
        cur_height = int'(height[COORD_W-1:0]);
    endtask

    // Stimulus: directed characters at the reset geometry, then phases of
    // random characters, each under its own screen setup.
    initial
    begin : stimulus
        int items;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every glyph at the origin, with each color channel at its extremes.
        send_char(0, 0, CHAR_H, 8'hFF, 8'hFF, 8'hFF);
        send_char(0, 0, CHAR_E, 8'hFF, 8'h00, 8'h00);
        send_char(0, 0, CHAR_L, 8'h00, 8'hFF, 8'h00);
        send_char(0, 0, CHAR_O, 8'h00, 8'h00, 8'hFF);
        send_char(0, 0, CHAR_BANG, 8'h00, 8'h00, 8'h00);
        // Tucked exactly into the bottom-right corner, then hanging past it.
        send_char(1016, 760, CHAR_H, 8'h12, 8'h34, 8'h56);
        send_char(1020, 765, CHAR_O, 8'hA5, 8'h5A, 8'hC3);
        // Hanging off the top-left corner.
        send_char(-4, -3, CHAR_E, 8'h3C, 8'hC3, 8'h81);
        // Only one corner pixel of the glyph left visible.
        send_char(-7, -7, CHAR_H, 8'h01, 8'h02, 8'h04);
        send_char(1023, 767, CHAR_H, 8'h80, 8'h40, 8'h20);
        // Clipped off every side; all but the last are fully hidden.
        send_char(-4096, -4096, CHAR_H, 8'hFF, 8'hFF, 8'hFF);
        send_char(4095, 4095, CHAR_L, 8'hFF, 8'hFF, 8'hFF);
        send_char(-8, 100, CHAR_O, 8'h77, 8'h88, 8'h99);
        send_char(100, 768, CHAR_E, 8'h77, 8'h88, 8'h99);
        send_char(500, -6, CHAR_BANG, 8'hDE, 8'hAD, 8'hBE);
        // Codes without a glyph.
        send_char(10, 10, CODE_LOWEST, 8'hFF, 8'hFF, 8'hFF);
        send_char(10, 10, CODE_HIGHEST, 8'hFF, 8'hFF, 8'hFF);

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            settle();
            case (phase)
                // Zero width, then zero height: everything is clipped.
                0: begin set_screen(16'd0, 16'd768, 16'd4096, 1'b0); items = 15; end
                1: begin set_screen(16'd1024, 16'd0, 16'd4096, 1'b0); items = 15; end
                // Largest width and pitch; the offset wraps and the pitch is
                // not a multiple of four. Upper width bits are dropped.
                2: begin set_screen(16'hFFFF, 16'd4096, 16'hFFFF, 1'b0); items = 70; end
                // Tiny screen with a pitch that is not a multiple of four.
                3: begin set_screen(16'd37, 16'd21, 16'd150, 1'b0); items = 70; end
                // Zero stride: every row lands on the first line.
                4: begin set_screen(16'd4096, 16'hE064, 16'd0, 1'b0); items = 50; end
                5: begin set_screen(16'd640, 16'd480, 16'd2560, 1'b1); items = 70; end
                default:
                begin
                    set_screen(($urandom_range(0, 7) == 0) ? 16'hFFFF
                                   : 16'($urandom_range(8, 4096)),
                               16'($urandom_range(8, 4096)), 16'($urandom_range(0, 65535)),
                               $urandom_range(0, 1) == 1);
                    items = 50;
                end
            endcase
            sender_steady = ($urandom_range(0, 3) == 0);
            repeat (items) begin
                send_char(pick_coord(cur_width), pick_coord(cur_height),
                          ($urandom_range(0, 9) < 7) ? glyph_codes[$urandom_range(0, 4)]
                                                     : 7'($urandom_range(0, 127)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)));
            end
        end

        settle();
        if (mismatches == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Receiver: alternates ready and stalled stretches of random length, with
    // one long hold-off partway through while the sender keeps offering, so
    // the block backs up and stops accepting characters.
    initial
    begin : receiver
        int cycles;
        int mode;
        bit long_hold_done;
        long_hold_done = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (!long_hold_done && items_sent >= HOLD_AFTER) begin
                long_hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else begin
                mode = $urandom_range(0, 9);
                if (mode == 0) begin
                    m_axis_tready <= 1'b1;
                    cycles = $urandom_range(50, 200);
                end
                else if (mode < 6) begin
                    m_axis_tready <= 1'b1;
                    cycles = $urandom_range(1, 8);
                end
                else begin
                    m_axis_tready <= 1'b0;
                    cycles = idle_len();
                    if (cycles == 0)
                        cycles = 1;
                end
                repeat (cycles) @(posedge clk);
            end
        end
    end

    // Watchdog: any accepted item on any channel counts as progress.
    always @(posedge clk) begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

endmodule

// File: sim.f
src/gpe_pkg.sv
src/glyph_pixel_expander.sv
verif/glyph_write_checker.sv
verif/tb.sv
